[hw/rtl/stmk_pkg.sv]
// Shared types and constants for the streaming top-m keeper.
package stmk_pkg;

    localparam int VALUE_W     = 32;
    localparam int KEEP_W      = 5;
    localparam int POS_W       = 4;
    localparam int DRAIN_LIMIT = 16;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_DRAIN = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_ROTATE = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic signed [VALUE_W-1:0]  sample;
    } t_cell_ctl;

endpackage

[hw/rtl/streaming_top_m_keeper.sv]
// Top level: keeps the largest values of a stream in a chain of cells.
//
//  port group       dir  transfer rule
//  start/i_cmd/...  in   taken at a clock edge with start high and busy low
//  o_strobe/o_...   out  one cycle per result, taken at the edge ending it
//  i_cfg_we/wdata   in   keep count written at any edge with i_cfg_we high
//
// Push while below the keep count: the sample is appended, busy stays low.
// Push when full: the chain rotates once to find the minimum (one cell
// per cycle past the head); a larger sample then drops the minimum and enters at the tail.
// Drain: the chain rotates once; each result is registered from the head.
// Reset clears the count and sets the keep count to 16; no clearing pass.
// Results cannot be stalled.
module streaming_top_m_keeper #(
    parameter int MAX_KEEP = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            i_cmd,
    input  logic signed [stmk_pkg::VALUE_W-1:0]   i_sample,
    input  logic                                  i_cfg_we,
    input  logic [stmk_pkg::KEEP_W-1:0]           i_cfg_wdata,
    output logic                                  o_strobe,
    output logic signed [stmk_pkg::VALUE_W-1:0]   o_kept_value,
    output logic [stmk_pkg::POS_W-1:0]            o_position,
    output logic                                  o_last
);

    localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam int W     = (CNT_W > stmk_pkg::KEEP_W) ? CNT_W + 1 : stmk_pkg::KEEP_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REPLACE,
        S_DRAIN
    } t_state;

    t_state                                r_state;
    logic [CNT_W-1:0]                      r_count;
    logic [stmk_pkg::KEEP_W-1:0]           r_keep;
    logic [IDX_W-1:0]                      r_k;
    logic [IDX_W-1:0]                      r_minpos;
    logic signed [stmk_pkg::VALUE_W-1:0]   r_minv;
    logic signed [stmk_pkg::VALUE_W-1:0]   r_sample;

    logic                                  accept;
    stmk_pkg::t_cmd                        cmd;
    logic [W-1:0]                          eff_keep;
    logic                                  can_append;
    logic [IDX_W-1:0]                      last_idx;
    logic [IDX_W-1:0]                      tail;
    stmk_pkg::t_cell_ctl                   cell_ctl;
    logic signed [stmk_pkg::VALUE_W-1:0]   w_value [MAX_KEEP];
    logic signed [stmk_pkg::VALUE_W-1:0]   head;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign cmd      = stmk_pkg::t_cmd'(i_cmd);
    assign head     = w_value[0];
    assign last_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        eff_keep = W'(r_keep);
        if (eff_keep == '0) eff_keep = W'(1);
        if (eff_keep > W'(MAX_KEEP)) eff_keep = W'(MAX_KEEP);
    end

    assign can_append = (W'(r_count) < eff_keep);

    always_comb begin
        cell_ctl.op     = stmk_pkg::CELL_HOLD;
        cell_ctl.sample = i_sample;
        tail            = last_idx;
        unique case (r_state)
            S_IDLE: begin
                if (accept && cmd == stmk_pkg::CMD_PUSH && can_append) begin
                    cell_ctl.op = stmk_pkg::CELL_APPEND;
                    tail        = IDX_W'(r_count);
                end
            end
            S_SCAN, S_DRAIN: cell_ctl.op = stmk_pkg::CELL_ROTATE;
            S_REPLACE: begin
                cell_ctl.sample = r_sample;
                if (r_sample > r_minv) cell_ctl.op = stmk_pkg::CELL_REMOVE;
            end
            default: cell_ctl.op = stmk_pkg::CELL_HOLD;
        endcase
    end

    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        logic signed [stmk_pkg::VALUE_W-1:0] next_value;
        if (g == MAX_KEEP - 1) begin : g_end
            assign next_value = '0;
        end else begin : g_mid
            assign next_value = w_value[g+1];
        end
        stmk_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_tail   (tail),
            .i_minpos (r_minpos),
            .i_next   (next_value),
            .i_head   (head),
            .o_value  (w_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_keep   <= stmk_pkg::KEEP_RESET;
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            o_last   <= 1'b0;
            if (i_cfg_we) r_keep <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (cmd)
                            stmk_pkg::CMD_PUSH: begin
                                if (can_append) begin
                                    r_count <= r_count + CNT_W'(1);
                                end else begin
                                    r_sample <= i_sample;
                                    r_k      <= '0;
                                    r_state  <= S_SCAN;
                                end
                            end
                            stmk_pkg::CMD_DRAIN: begin
                                if (r_count != '0) begin
                                    r_k     <= '0;
                                    r_state <= S_DRAIN;
                                end
                            end
                            stmk_pkg::CMD_CLEAR: r_count <= '0;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_k == '0 || head <= r_minv) begin
                        r_minv   <= head;
                        r_minpos <= r_k;
                    end
                    if (r_k == last_idx) r_state <= S_REPLACE;
                    else r_k <= r_k + IDX_W'(1);
                end
                S_REPLACE: r_state <= S_IDLE;
                S_DRAIN: begin
                    if (W'(r_k) < W'(stmk_pkg::DRAIN_LIMIT)) begin
                        o_strobe     <= 1'b1;
                        o_kept_value <= head;
                        o_position   <= stmk_pkg::POS_W'(r_k);
                        o_last       <= (r_k == last_idx)
                                     || (W'(r_k) == W'(stmk_pkg::DRAIN_LIMIT - 1));
                    end
                    if (r_k == last_idx) r_state <= S_IDLE;
                    else r_k <= r_k + IDX_W'(1);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_strobe_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DRAIN))
        else $error("result strobe outside a drain");

    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last flag without result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W'(r_count) <= W'(MAX_KEEP))
        else $error("held count above store depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cmd == stmk_pkg::CMD_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    a_scan_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("count changed during minimum scan");

endmodule

[hw/rtl/stmk_cell.sv]
// One storage cell of the keeper chain.
module stmk_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic                                  i_clk,
    input  stmk_pkg::t_cell_ctl                   i_ctl,
    input  logic [IDX_W-1:0]                      i_tail,
    input  logic [IDX_W-1:0]                      i_minpos,
    input  logic signed [stmk_pkg::VALUE_W-1:0]   i_next,
    input  logic signed [stmk_pkg::VALUE_W-1:0]   i_head,
    output logic signed [stmk_pkg::VALUE_W-1:0]   o_value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [stmk_pkg::VALUE_W-1:0] r_value;
    logic signed [stmk_pkg::VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            stmk_pkg::CELL_APPEND: begin
                if (MY_IDX == i_tail) n_value = i_ctl.sample;
            end
            stmk_pkg::CELL_ROTATE: begin
                if (MY_IDX < i_tail) n_value = i_next;
                else if (MY_IDX == i_tail) n_value = i_head;
            end
            stmk_pkg::CELL_REMOVE: begin
                if (MY_IDX >= i_minpos && MY_IDX < i_tail) n_value = i_next;
                else if (MY_IDX == i_tail) n_value = i_ctl.sample;
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
